// ===== sv/y86f_pkg.sv =====
// Shared types, constants and decode helpers for the Y86-64 fetch stage.
package y86f_pkg;

	// Instruction memory defaults and banking
	localparam int MEM_BYTES_DEF = 4096;
	localparam int BANKS         = 16;
	localparam int BANK_BITS     = 4;
	localparam int FETCH_BYTES   = 10;

	// Stream widths
	localparam int IN_DATA_W  = 160;
	localparam int RES_W      = 273;
	localparam int OUT_DATA_W = 280;

	// Request kinds carried in the input tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	// Instruction codes
	localparam logic [3:0] IC_RRMOVQ = 4'h2;
	localparam logic [3:0] IC_IRMOVQ = 4'h3;
	localparam logic [3:0] IC_RMMOVQ = 4'h4;
	localparam logic [3:0] IC_MRMOVQ = 4'h5;
	localparam logic [3:0] IC_OPQ    = 4'h6;
	localparam logic [3:0] IC_JXX    = 4'h7;
	localparam logic [3:0] IC_CALL   = 4'h8;
	localparam logic [3:0] IC_RET    = 4'h9;
	localparam logic [3:0] IC_PUSHQ  = 4'hA;
	localparam logic [3:0] IC_POPQ   = 4'hB;
	localparam logic [3:0] REG_NONE  = 4'hF;

	// One fetch result, fetch_pc in the lowest bits
	typedef struct packed {
		logic        fetch_fault;
		logic [63:0] predicted_next;
		logic [63:0] next_seq_pc;
		logic [63:0] const_word;
		logic [3:0]  reg_b;
		logic [3:0]  reg_a;
		logic [3:0]  op_ifun;
		logic [3:0]  op_icode;
		logic [63:0] fetch_pc;
	} fetch_res_t;

	// Instruction carries a register specifier byte
	function automatic logic has_regs(input logic [3:0] ic);
		return (ic == IC_RRMOVQ) || (ic == IC_OPQ) || (ic == IC_PUSHQ) ||
			(ic == IC_POPQ) || (ic == IC_IRMOVQ) || (ic == IC_RMMOVQ) ||
			(ic == IC_MRMOVQ);
	endfunction

	// Instruction carries an 8-byte constant word
	function automatic logic has_const(input logic [3:0] ic);
		return (ic == IC_IRMOVQ) || (ic == IC_RMMOVQ) || (ic == IC_MRMOVQ) ||
			(ic == IC_JXX) || (ic == IC_CALL);
	endfunction

	// Instruction length in bytes: 1 + register byte + constant word
	function automatic logic [3:0] instr_len(input logic [3:0] ic);
		return 4'd1 + {3'b000, has_regs(ic)} + {has_const(ic), 3'b000};
	endfunction

endpackage

// ===== sv/y86_pipeline_fetch_stage.sv =====
// Top level of the Y86-64 pipeline fetch stage with banked instruction memory.
//
// Input stream (s_axis): tuser selects the kind of transaction. A load transaction
// writes one byte of instruction memory and gives no result; a fetch transaction
// selects the PC (jump fall-through on a mispredicted branch, return address on
// RET, else the stored prediction), reads up to ten bytes there and gives one
// result transaction on m_axis.
// Pipeline: a fetch passes the memory read stage and then the output register
// before it shows on m_axis.
// Throughput: one transaction per cycle, fetches back to back, while results
// are taken. The next-PC loop runs through the 16 byte-wide memory banks (one row
// read each), the decode, the valP adder and the next fetch's bank row address.
// Memory: MEM_BYTES bytes in 16 banks of MEM_BYTES/16 rows, rounded up; contents
// are undefined until written, and writes at or beyond MEM_BYTES are dropped.
// Reset: the predicted PC clears to 0 and both pipeline registers empty.
// Receiver stall: the output register holds its result, the decoded fetch
// behind it waits in the read stage, and s_axis_tready drops only while both
// are full and the output is not taken.
module y86_pipeline_fetch_stage #(
	parameter int MEM_BYTES = y86f_pkg::MEM_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [11:0] load_addr, [19:12] load_byte, [23:20] mem_icode, [24] mem_cond,
	// [88:25] mem_vala, [92:89] wb_icode, [156:93] wb_valm, [159:157] zero
	input  logic [y86f_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] req_type
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [63:0] fetch_pc, [67:64] op_icode, [71:68] op_ifun, [75:72] reg_a,
	// [79:76] reg_b, [143:80] const_word, [207:144] next_seq_pc,
	// [271:208] predicted_next, [272] fetch_fault, [279:273] zero
	output logic [y86f_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	localparam int ROWS = (MEM_BYTES + y86f_pkg::BANKS - 1) / y86f_pkg::BANKS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int XW   = RW + y86f_pkg::BANK_BITS;

	// Input fields
	logic [11:0] load_addr;
	logic [7:0]  load_byte;
	logic [3:0]  mem_icode;
	logic        mem_cond;
	logic [63:0] mem_vala;
	logic [3:0]  wb_icode;
	logic [63:0] wb_valm;

	assign load_addr = s_axis_tdata[11:0];
	assign load_byte = s_axis_tdata[19:12];
	assign mem_icode = s_axis_tdata[23:20];
	assign mem_cond  = s_axis_tdata[24];
	assign mem_vala  = s_axis_tdata[88:25];
	assign wb_icode  = s_axis_tdata[92:89];
	assign wb_valm   = s_axis_tdata[156:93];

	logic                                s_acc;
	logic                                fetch_acc;
	logic                                load_acc;
	logic                                valid_s1;
	logic [63:0]                         pc_s1;
	logic                                adv_s1;
	logic                                out_valid_q;
	y86f_pkg::fetch_res_t                out_q;
	y86f_pkg::fetch_res_t                res_s1;
	logic [63:0]                         pred_pc_q;
	logic [63:0]                         cur_pred;
	logic [63:0]                         pc_sel;
	logic [XW-1:0]                       ld_ext;
	logic                                ld_in_range;
	logic [y86f_pkg::BANKS-1:0][7:0]     bank_q;

	// Handshake
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign fetch_acc     = s_acc && (s_axis_tuser == y86f_pkg::REQ_FETCH);
	assign load_acc      = s_acc && (s_axis_tuser == y86f_pkg::REQ_LOAD);

	// Forward the prediction of the fetch still in the read stage
	assign cur_pred = valid_s1 ? res_s1.predicted_next : pred_pc_q;

	// Select the fetch PC
	always_comb begin
		priority if ((mem_icode == y86f_pkg::IC_JXX) && !mem_cond) begin
			pc_sel = mem_vala;
		end else if (wb_icode == y86f_pkg::IC_RET) begin
			pc_sel = wb_valm;
		end else begin
			pc_sel = cur_pred;
		end
	end

	// Load address split into bank and row
	assign ld_ext      = XW'(32'(load_addr));
	assign ld_in_range = 32'(load_addr) < MEM_BYTES;

	// One bank per low address nibble; lanes before the PC nibble use the next row
	for (genvar b = 0; b < y86f_pkg::BANKS; b++) begin : g_bank
		logic          we_b;
		logic [RW-1:0] rd_row;

		assign we_b   = load_acc && ld_in_range &&
			(ld_ext[y86f_pkg::BANK_BITS-1:0] == y86f_pkg::BANK_BITS'(b));
		assign rd_row = pc_sel[XW-1:y86f_pkg::BANK_BITS] +
			RW'(pc_sel[y86f_pkg::BANK_BITS-1:0] > y86f_pkg::BANK_BITS'(b));

		y86f_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (we_b),
			.waddr(ld_ext[XW-1:y86f_pkg::BANK_BITS]),
			.wdata(load_byte),
			.re   (fetch_acc),
			.raddr(rd_row),
			.rdata(bank_q[b])
		);
	end

	// Decode the fetched bytes
	y86f_decode #(
		.MEM_BYTES(MEM_BYTES)
	) u_decode (
		.pc       (pc_s1),
		.bank_data(bank_q),
		.res      (res_s1)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pred_pc_q   <= 64'd0;
		end else begin
			if (fetch_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
				pred_pc_q   <= res_s1.predicted_next;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold the PC in the read stage, advance the result to the output
	always_ff @(posedge clk) begin
		if (fetch_acc) begin
			pc_s1 <= pc_sel;
		end
		if (adv_s1) begin
			out_q <= res_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(y86f_pkg::OUT_DATA_W - y86f_pkg::RES_W)'(0), out_q};

endmodule

// ===== sv/y86f_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module y86f_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/y86f_decode.sv =====
// Byte alignment, instruction split, valC/valP and next-PC prediction.
module y86f_decode #(
	parameter int MEM_BYTES = y86f_pkg::MEM_BYTES_DEF
) (
	input  logic [63:0]                         pc,
	input  logic [y86f_pkg::BANKS-1:0][7:0]     bank_data,
	output y86f_pkg::fetch_res_t                res
);

	logic [y86f_pkg::FETCH_BYTES-1:0][7:0] ibyte;
	logic [y86f_pkg::FETCH_BYTES-1:0]      flt;
	logic [3:0]                            ic;
	logic                                  nr;
	logic                                  nc;
	logic [63:0]                           valc;
	logic [63:0]                           valp;

	// Pick each instruction byte from its bank, zero it beyond memory
	always_comb begin
		for (int k = 0; k < y86f_pkg::FETCH_BYTES; k++) begin
			flt[k]   = (pc + 64'(k)) >= 64'(MEM_BYTES);
			ibyte[k] = flt[k] ? 8'h00 : bank_data[4'(pc[3:0] + 4'(k))];
		end
	end

	assign ic = ibyte[0][7:4];
	assign nr = y86f_pkg::has_regs(ic);
	assign nc = y86f_pkg::has_const(ic);

	// Constant word follows the register byte when there is one
	assign valc = !nc ? 64'd0 : (nr ? ibyte[9:2] : ibyte[8:1]);
	assign valp = pc + 64'(y86f_pkg::instr_len(ic));

	// Assemble the result
	always_comb begin
		res.fetch_pc       = pc;
		res.op_icode       = ic;
		res.op_ifun        = ibyte[0][3:0];
		res.reg_a          = nr ? ibyte[1][7:4] : y86f_pkg::REG_NONE;
		res.reg_b          = nr ? ibyte[1][3:0] : y86f_pkg::REG_NONE;
		res.const_word     = valc;
		res.next_seq_pc    = valp;
		res.predicted_next = ((ic == y86f_pkg::IC_JXX) || (ic == y86f_pkg::IC_CALL)) ?
			valc : valp;
		res.fetch_fault    = flt[0] | (nr & flt[1]) |
			(nc & (nr ? (|flt[9:2]) : (|flt[8:1])));
	end

endmodule

// ===== sv/y86f_checker.sv =====
// Port-level checks on the fetch stage result stream, bound to the top level.
module y86f_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [y86f_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	y86f_pkg::fetch_res_t res;

	assign res = y86f_pkg::fetch_res_t'(m_axis_tdata[y86f_pkg::RES_W-1:0]);

	// A stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// valP follows from the PC and the instruction length
	a_valp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		res.next_seq_pc == res.fetch_pc + 64'(y86f_pkg::instr_len(res.op_icode)))
		else $error("valP does not match instruction length");

	// Jumps and calls predict valC, everything else valP
	a_pred: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		res.predicted_next == (((res.op_icode == y86f_pkg::IC_JXX) ||
			(res.op_icode == y86f_pkg::IC_CALL)) ? res.const_word : res.next_seq_pc))
		else $error("wrong next-PC prediction");

	// Absent register byte and constant read as none and zero
	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(y86f_pkg::has_regs(res.op_icode) ||
			(res.reg_a == y86f_pkg::REG_NONE && res.reg_b == y86f_pkg::REG_NONE)) &&
		(y86f_pkg::has_const(res.op_icode) || res.const_word == 64'd0))
		else $error("absent field not cleared");

endmodule

bind y86_pipeline_fetch_stage y86f_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
